FILE: hw/rtl/flrt_pkg.sv
// shared types and constants for the fixed-latency read tracker
`default_nettype none

package flrt_pkg;

	localparam int TXID_W = 4;
	localparam int ADDR_W = 32;
	localparam int AGE_W = 8;
	localparam logic [AGE_W-1:0] AGE_MAX = '1;
	localparam logic [AGE_W-1:0] MISS_LATENCY_RST = 8'd8;
	localparam int NUM_TXIDS_DEF = 16;
	localparam int LINE_BYTES_DEF = 64;

	typedef struct packed {
		logic              rd_req_en;
		logic [ADDR_W-1:0] req_address;
		logic [TXID_W-1:0] req_txid;
		logic              retire_valid;
		logic [TXID_W-1:0] retire_txid;
	} request_t;

	typedef struct packed {
		logic              resp_ready_flag;
		logic [TXID_W-1:0] resp_txid;
		logic [ADDR_W-1:0] resp_line_address;
		logic              duplicate_error;
	} result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/flrt_mature_pick.sv
// finds the lowest-numbered valid entry whose age has reached the latency
`default_nettype none

module flrt_mature_pick #(
	parameter int NUM_TXIDS = flrt_pkg::NUM_TXIDS_DEF,
	localparam int IDX_W = (NUM_TXIDS > 1) ? $clog2(NUM_TXIDS) : 1
) (
	input  wire logic [NUM_TXIDS-1:0]                   valid,
	input  wire logic [NUM_TXIDS-1:0][flrt_pkg::AGE_W-1:0] age,
	input  wire logic [flrt_pkg::AGE_W-1:0]             latency,
	output logic                                        hit,
	output logic [IDX_W-1:0]                            idx
);

	logic [NUM_TXIDS-1:0] mature;

	always_comb begin
		for (int i = 0; i < NUM_TXIDS; i++) begin
			mature[i] = valid[i] && (age[i] >= latency);
		end
	end

	// priority encoder, lowest index wins
	always_comb begin
		hit = 1'b0;
		idx = '0;
		for (int i = NUM_TXIDS - 1; i >= 0; i--) begin
			if (mature[i]) begin
				hit = 1'b1;
				idx = IDX_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/fixed_latency_read_tracker.sv
// top level of the fixed-latency outstanding read tracker
`default_nettype none

// Tracks up to NUM_TXIDS outstanding line reads by transaction ID and reports
// the lowest-numbered one whose age has reached miss_latency. The block takes
// one request per cycle: busy is always low. Each request is registered, then
// checked against the entry table and applied to it in the following cycle,
// so its result passes the input and result registers and is on result with
// done high for exactly one cycle, and is taken at the edge that ends it;
// results come out in request order and must be taken as they appear, since
// the receiver cannot hold them off. The reported entry reflects the table
// before that request's update. Write miss_latency only while no request is
// in flight.
module fixed_latency_read_tracker #(
	parameter int NUM_TXIDS = flrt_pkg::NUM_TXIDS_DEF,
	parameter int LINE_BYTES = flrt_pkg::LINE_BYTES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire flrt_pkg::request_t           request,
	output logic                              done,
	output flrt_pkg::result_t                 result,
	input  wire logic                         miss_latency_we,
	input  wire logic [flrt_pkg::AGE_W-1:0]   miss_latency_wdata
);

	localparam int IDX_W = (NUM_TXIDS > 1) ? $clog2(NUM_TXIDS) : 1;
	localparam logic [flrt_pkg::ADDR_W-1:0] LINE_MASK =
		~(flrt_pkg::ADDR_W'(LINE_BYTES) - flrt_pkg::ADDR_W'(1));
	localparam logic [flrt_pkg::TXID_W:0] ID_LIMIT = (flrt_pkg::TXID_W + 1)'(NUM_TXIDS);

	logic [flrt_pkg::AGE_W-1:0] miss_latency_q;

	logic               req_vld_s1;
	flrt_pkg::request_t req_s1;

	logic [NUM_TXIDS-1:0]                           valid_q;
	logic [NUM_TXIDS-1:0][flrt_pkg::AGE_W-1:0]      age_q;
	logic [flrt_pkg::ADDR_W-1:0]                    addr_q [NUM_TXIDS];

	logic [NUM_TXIDS-1:0]                           valid_d;
	logic [NUM_TXIDS-1:0][flrt_pkg::AGE_W-1:0]      age_d;

	logic              hit;
	logic [IDX_W-1:0]  hit_idx;
	logic              req_ok;
	logic              ret_ok;
	logic [IDX_W-1:0]  req_idx;
	logic [IDX_W-1:0]  ret_idx;
	logic              dup;
	logic              alloc;

	logic              done_q;
	flrt_pkg::result_t result_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_latency_q <= flrt_pkg::MISS_LATENCY_RST;
		end else if (miss_latency_we) begin
			miss_latency_q <= miss_latency_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s1 <= 1'b0;
		end else begin
			req_vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= request;
		end
	end

	flrt_mature_pick #(
		.NUM_TXIDS(NUM_TXIDS)
	) u_pick (
		.valid   (valid_q),
		.age     (age_q),
		.latency (miss_latency_q),
		.hit     (hit),
		.idx     (hit_idx)
	);

	assign req_ok = ({1'b0, req_s1.req_txid} < ID_LIMIT);
	assign ret_ok = ({1'b0, req_s1.retire_txid} < ID_LIMIT);
	assign req_idx = req_s1.req_txid[IDX_W-1:0];
	assign ret_idx = req_s1.retire_txid[IDX_W-1:0];
	assign dup = req_vld_s1 && req_s1.rd_req_en && req_ok && valid_q[req_idx];
	assign alloc = req_vld_s1 && req_s1.rd_req_en && req_ok && !valid_q[req_idx];

	// age, allocate, then retire
	always_comb begin
		valid_d = valid_q;
		age_d = age_q;
		if (req_vld_s1) begin
			for (int i = 0; i < NUM_TXIDS; i++) begin
				if (valid_q[i] && (age_q[i] != flrt_pkg::AGE_MAX)) begin
					age_d[i] = age_q[i] + flrt_pkg::AGE_W'(1);
				end
			end
			if (alloc) begin
				valid_d[req_idx] = 1'b1;
				age_d[req_idx] = '0;
			end
			if (req_s1.retire_valid && ret_ok) begin
				valid_d[ret_idx] = 1'b0;
				age_d[ret_idx] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			age_q <= '0;
		end else begin
			valid_q <= valid_d;
			age_q <= age_d;
		end
	end

	always_ff @(posedge clk) begin
		if (alloc) begin
			addr_q[req_idx] <= req_s1.req_address & LINE_MASK;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= req_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_vld_s1) begin
			result_q.resp_ready_flag <= hit;
			result_q.resp_txid <= hit ? flrt_pkg::TXID_W'(hit_idx) : '0;
			result_q.resp_line_address <= hit ? addr_q[hit_idx] : '0;
			result_q.duplicate_error <= dup;
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

`default_nettype wire
